FILE: hw/rtl/skt_pkg.sv
// Shared types, field widths and codes for the sorted key table.
package skt_pkg;

	localparam int unsigned TableDepthDef = 1024;
	localparam int unsigned CountBits     = 24;

	localparam int unsigned ActW  = 3;
	localparam int unsigned KeyW  = 32;
	localparam int unsigned ImgW  = 32;
	localparam int unsigned CodeW = 16;
	localparam int unsigned SeqW  = 10;
	localparam int unsigned StatW = 2;

	localparam logic [ActW-1:0] ACT_LOAD         = 3'd0;
	localparam logic [ActW-1:0] ACT_LOOKUP       = 3'd1;
	localparam logic [ActW-1:0] ACT_BUMP_VALID   = 3'd2;
	localparam logic [ActW-1:0] ACT_BUMP_INVALID = 3'd3;
	localparam logic [ActW-1:0] ACT_READ         = 3'd4;
	localparam logic [ActW-1:0] ACT_CLEAR        = 3'd5;

	localparam logic [StatW-1:0] STAT_OK   = 2'd0;
	localparam logic [StatW-1:0] STAT_FULL = 2'd1;
	localparam logic [StatW-1:0] STAT_SEQ  = 2'd2;

	typedef struct packed {
		logic [ActW-1:0]         action;
		logic [KeyW-1:0]         ext_id;
		logic [ImgW-1:0]         image_id;
		logic signed [CodeW-1:0] photcode;
		logic [SeqW-1:0]         seq;
	} req_t;

	typedef struct packed {
		logic [StatW-1:0]        status;
		logic                    found;
		logic                    duplicate;
		logic [ImgW-1:0]         match_image_id;
		logic signed [CodeW-1:0] match_photcode;
		logic [SeqW-1:0]         match_seq;
		logic [CountBits-1:0]    valid_count;
		logic [CountBits-1:0]    invalid_count;
	} rsp_t;

endpackage

FILE: hw/rtl/skt_if.sv
// Request and response channel interfaces for the sorted key table.
interface skt_req_if import skt_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/skt_ram.sv
// Simple dual-port synchronous RAM with one registered read port.
module skt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/sorted_key_table_lookup_counters.sv
// Top level: sorted key table with binary-search lookup and hit counters.
//
//   Channel   Direction   Carries
//   -------   ---------   ------------------------------------------------
//   req       in          one item: action, ext_id, image_id, photcode, seq
//   rsp       out         one item per request: status, match data, counts
//
// Steps per item: a counter bump or read passes through the counter update
// state, and an item that only reports a status (table full, sequence out
// of range, unused action) goes straight to its result. A lookup makes at
// most ceil(log2(entries + 1)) probes into the entry RAM; a miss ends sooner.
// A load moves each larger key up one slot, and each shifted entry costs
// one read-modify-write slot of the entry RAM.
// A clear sweeps the counter RAM one word per cycle.
// After reset the same sweep runs once before the first item is taken.
// A result waits in the output register; a new item is taken meanwhile and
// holds only in its last state if the previous result has not gone out.
module sorted_key_table_lookup_counters import skt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
	input  logic  clk,
	input  logic  arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);

	localparam int unsigned AW   = $clog2(TABLE_DEPTH);
	localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned CNTW = 2 * CountBits;

	// One table entry, kept sorted by key in the entry RAM.
	typedef struct packed {
		logic [KeyW-1:0]         key;
		logic [ImgW-1:0]         image;
		logic signed [CodeW-1:0] code;
		logic [AW-1:0]           order;
	} entry_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_INS, S_INS_LAST, S_LK_PROBE, S_LK_HIT,
		S_LK_DUP, S_LK_CNT, S_CNT_UPD, S_DONE
	} state_t;

	state_t        state_q;
	req_t          item_q;
	rsp_t          res_q;
	rsp_t          out_q;
	logic          out_valid_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [AW-1:0] mid_q;
	logic [CW-1:0] pos_q;
	logic [AW-1:0] order_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_rsp_q;

	logic          ent_we;
	logic [AW-1:0] ent_waddr;
	entry_t        ent_wdata;
	logic [AW-1:0] ent_raddr;
	entry_t        ent_rdata;

	logic            cnt_we;
	logic [AW-1:0]   cnt_waddr;
	logic [CNTW-1:0] cnt_wdata;
	logic [AW-1:0]   cnt_raddr;
	logic [CNTW-1:0] cnt_rdata;

	logic                 req_fire;
	logic                 key_lt;
	logic                 key_gt;
	logic                 key_eq;
	logic [CW-1:0]        lo_nx;
	logic [CW-1:0]        hi_nx;
	logic [CW:0]          sum_nx;
	logic [AW-1:0]        mid_nx;
	entry_t               new_ent;
	logic [CountBits-1:0] cur_v;
	logic [CountBits-1:0] cur_i;
	logic [CountBits-1:0] nxt_v;
	logic [CountBits-1:0] nxt_i;

	skt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// Counters are addressed by load order, valid count in the upper half.
	skt_ram #(.WIDTH(CNTW), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Compare the entry read last cycle against the held key.
	assign key_lt = ent_rdata.key < item_q.ext_id;
	assign key_gt = ent_rdata.key > item_q.ext_id;
	assign key_eq = ent_rdata.key == item_q.ext_id;

	// Next bisection bounds: the search finds the first key not below the request.
	assign lo_nx  = key_lt ? CW'(CW'(mid_q) + 1'b1) : lo_q;
	assign hi_nx  = key_lt ? hi_q : CW'(mid_q);
	assign sum_nx = {1'b0, lo_nx} + {1'b0, hi_nx};
	assign mid_nx = AW'(sum_nx >> 1);

	assign new_ent = '{key: item_q.ext_id, image: item_q.image_id,
		code: item_q.photcode, order: AW'(n_q)};

	// Saturating bump of the counter pair read for this item.
	assign cur_v = cnt_rdata[CNTW-1:CountBits];
	assign cur_i = cnt_rdata[CountBits-1:0];
	assign nxt_v = (item_q.action == ACT_BUMP_VALID && cur_v != '1) ?
		cur_v + 1'b1 : cur_v;
	assign nxt_i = (item_q.action == ACT_BUMP_INVALID && cur_i != '1) ?
		cur_i + 1'b1 : cur_i;

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = '0;
		ent_wdata = new_ent;
		ent_raddr = '0;
		cnt_we    = 1'b0;
		cnt_waddr = '0;
		cnt_wdata = '0;
		cnt_raddr = '0;
		unique case (state_q)
			S_CLR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_addr_q;
			end
			S_IDLE: begin
				// Prime the first read for whichever action arrives.
				if (req.data.action == ACT_LOOKUP) begin
					ent_raddr = AW'(n_q >> 1);
				end else begin
					ent_raddr = AW'(n_q - 1'b1);
				end
				cnt_raddr = AW'(req.data.seq);
			end
			S_INS: begin
				// Walk down from the top, moving larger keys up by one slot.
				ent_we    = 1'b1;
				ent_waddr = AW'(pos_q);
				if (key_gt) begin
					ent_wdata = ent_rdata;
					ent_raddr = AW'(pos_q - 2'd2);
				end
			end
			S_INS_LAST: begin
				ent_we    = 1'b1;
				ent_waddr = AW'(pos_q);
			end
			S_LK_PROBE: begin
				ent_raddr = (lo_nx < hi_nx) ? mid_nx : AW'(lo_nx);
			end
			S_LK_HIT: begin
				ent_raddr = AW'(lo_q + 1'b1);
			end
			S_LK_DUP: begin
				cnt_raddr = order_q;
			end
			S_CNT_UPD: begin
				cnt_we    = (item_q.action == ACT_BUMP_VALID) ||
					(item_q.action == ACT_BUMP_INVALID);
				cnt_waddr = AW'(item_q.seq);
				cnt_wdata = {nxt_v, nxt_i};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			pos_q       <= '0;
			order_q     <= '0;
			clr_addr_q  <= '0;
			clr_rsp_q   <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(TABLE_DEPTH - 1)) begin
						clr_addr_q <= '0;
						clr_rsp_q  <= 1'b0;
						state_q    <= clr_rsp_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						item_q <= req.data;
						res_q  <= '0;
						case (req.data.action)
							ACT_LOAD: begin
								if (n_q == CW'(TABLE_DEPTH)) begin
									res_q.status <= STAT_FULL;
									state_q      <= S_DONE;
								end else if (n_q == '0) begin
									pos_q   <= '0;
									state_q <= S_INS_LAST;
								end else begin
									pos_q   <= n_q;
									state_q <= S_INS;
								end
							end
							ACT_LOOKUP: begin
								lo_q    <= '0;
								hi_q    <= n_q;
								mid_q   <= AW'(n_q >> 1);
								state_q <= (n_q == '0) ? S_DONE : S_LK_PROBE;
							end
							ACT_BUMP_VALID, ACT_BUMP_INVALID, ACT_READ: begin
								if (32'(req.data.seq) >= 32'(n_q)) begin
									res_q.status <= STAT_SEQ;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_CNT_UPD;
								end
							end
							ACT_CLEAR: begin
								clr_addr_q <= '0;
								clr_rsp_q  <= 1'b1;
								state_q    <= S_CLR;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INS: begin
					if (key_gt) begin
						pos_q <= pos_q - 1'b1;
						if (pos_q == CW'(1)) begin
							state_q <= S_INS_LAST;
						end
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_INS_LAST: begin
					n_q     <= n_q + 1'b1;
					state_q <= S_DONE;
				end
				S_LK_PROBE: begin
					lo_q  <= lo_nx;
					hi_q  <= hi_nx;
					mid_q <= mid_nx;
					if (!(lo_nx < hi_nx)) begin
						state_q <= (lo_nx == n_q) ? S_DONE : S_LK_HIT;
					end
				end
				S_LK_HIT: begin
					if (key_eq) begin
						res_q.found          <= 1'b1;
						res_q.match_image_id <= ent_rdata.image;
						res_q.match_photcode <= ent_rdata.code;
						res_q.match_seq      <= SeqW'(ent_rdata.order);
						order_q              <= ent_rdata.order;
						state_q              <= S_LK_DUP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LK_DUP: begin
					res_q.duplicate <= (CW'(lo_q + 1'b1) < n_q) && key_eq;
					state_q         <= S_LK_CNT;
				end
				S_LK_CNT: begin
					res_q.valid_count   <= cur_v;
					res_q.invalid_count <= cur_i;
					state_q             <= S_DONE;
				end
				S_CNT_UPD: begin
					res_q.valid_count   <= nxt_v;
					res_q.invalid_count <= nxt_i;
					state_q             <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The entry count never runs past the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// Loads add exactly one entry at a time.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(n_q) |-> n_q == CW'($past(n_q) + 1'b1))
		else $error("entry count changed by other than one");

	// A reported duplicate always comes with a match.
	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.duplicate |-> out_q.found)
		else $error("duplicate flag without a match");

	// The counter sweep never disturbs the entry table.
	a_clr_no_ent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !ent_we)
		else $error("entry write during counter sweep");

endmodule

FILE: tb/testbench.sv
// Testbench for the sorted key table: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module testbench;
	import skt_pkg::*;

	// Action codes that the block ignores.
	localparam logic [ActW-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ActW-1:0] ACT_SPARE_HI = 3'd7;

	// The scoreboard keeps its own copy of the table and the hit counters.
	// It works out the result of each accepted item and queues it until the
	// block's result for that item comes out.
	class table_scoreboard;
		logic [KeyW-1:0]         keys[$];
		logic [ImgW-1:0]         images[$];
		logic signed [CodeW-1:0] codes[$];
		int unsigned             orders[$];
		logic [CountBits-1:0]    valid_hits[TableDepthDef];
		logic [CountBits-1:0]    invalid_hits[TableDepthDef];
		rsp_t                    awaited[$];
		bit                      failed;

		function new();
			foreach (valid_hits[i]) begin
				valid_hits[i] = '0;
				invalid_hits[i] = '0;
			end
			failed = 0;
		endfunction

		function int unsigned entries();
			return keys.size();
		endfunction

		// Notes an accepted item and queues the result it must cause.
		function void note_item(req_t r);
			rsp_t o;
			int unsigned pos;
			int unsigned n;
			o = '0;
			n = keys.size();
			case (r.action)
				ACT_LOAD: begin
					if (n >= TableDepthDef) begin
						o.status = STAT_FULL;
					end else begin
						// A new entry goes after every entry with an equal key.
						pos = 0;
						while (pos < n && keys[pos] <= r.ext_id)
							pos++;
						keys.insert(pos, r.ext_id);
						images.insert(pos, r.image_id);
						codes.insert(pos, r.photcode);
						orders.insert(pos, n);
					end
				end
				ACT_LOOKUP: begin
					pos = 0;
					while (pos < n && keys[pos] < r.ext_id)
						pos++;
					if (pos < n && keys[pos] == r.ext_id) begin
						o.found = 1'b1;
						o.duplicate = (pos + 1 < n) && (keys[pos + 1] == r.ext_id);
						o.match_image_id = images[pos];
						o.match_photcode = codes[pos];
						o.match_seq = orders[pos][SeqW-1:0];
						o.valid_count = valid_hits[orders[pos]];
						o.invalid_count = invalid_hits[orders[pos]];
					end
				end
				ACT_BUMP_VALID, ACT_BUMP_INVALID, ACT_READ: begin
					if (r.seq >= n) begin
						o.status = STAT_SEQ;
					end else begin
						// Counters stick at their all-ones value.
						if (r.action == ACT_BUMP_VALID && valid_hits[r.seq] != '1)
							valid_hits[r.seq]++;
						if (r.action == ACT_BUMP_INVALID && invalid_hits[r.seq] != '1)
							invalid_hits[r.seq]++;
						o.valid_count = valid_hits[r.seq];
						o.invalid_count = invalid_hits[r.seq];
					end
				end
				ACT_CLEAR: begin
					foreach (valid_hits[i]) begin
						valid_hits[i] = '0;
						invalid_hits[i] = '0;
					end
				end
				default: ;
			endcase
			awaited.push_back(o);
		endfunction

		function void field_diff(string name, longint unsigned exp_v, longint unsigned act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
					act_v);
				failed = 1;
			end
		endfunction

		// Compares one result of the block with the oldest expectation.
		function void check_result(rsp_t a);
			rsp_t e;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, a);
				failed = 1;
				return;
			end
			e = awaited.pop_front();
			field_diff("status", e.status, a.status);
			field_diff("found", e.found, a.found);
			field_diff("duplicate", e.duplicate, a.duplicate);
			field_diff("match_image_id", e.match_image_id, a.match_image_id);
			field_diff("match_photcode", e.match_photcode, a.match_photcode);
			field_diff("match_seq", e.match_seq, a.match_seq);
			field_diff("valid_count", e.valid_count, a.valid_count);
			field_diff("invalid_count", e.invalid_count, a.invalid_count);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	skt_req_if req ();
	skt_rsp_if rsp ();

	sorted_key_table_lookup_counters uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	table_scoreboard sb = new();

	// Set by the stimulus to ask the receiver for one long stall.
	int hold_len = 0;
	// Keys that random items reuse, so that duplicates and lookup hits are common.
	logic [KeyW-1:0] key_pool[16];

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Results are taken at the edge where valid and ready are both high.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.data);
	end

	// The receiver changes its mood after each random span: always ready,
	// ready half the time, or mostly stalled. On request it holds off for a
	// long stretch so that the block backs up into its input.
	initial begin
		int mode;
		int span;
		int stall_for;
		rsp.ready = 1'b0;
		forever begin
			if (hold_len > 0) begin
				stall_for = hold_len;
				hold_len = 0;
				rsp.ready <= 1'b0;
				repeat (stall_for) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			span = $urandom_range(10, 60);
			repeat (span) begin
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= 1'($urandom_range(0, 1));
					default: rsp.ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Offers one item and holds it until the block takes it. Valid stays
	// high afterwards so back-to-back items need no gap.
	task automatic send_item(req_t r);
		req.valid <= 1'b1;
		req.data <= r;
		do
			@(posedge clk);
		while (!req.ready);
		sb.note_item(r);
	endtask

	task automatic idle(int cycles);
		req.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Sender bursts: after each item the burst may end with a random gap.
	int burst_left = 0;
	task automatic paced_send(req_t r);
		send_item(r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0)
				idle($urandom_range(1, 15));
		end else begin
			burst_left--;
		end
	endtask

	function automatic req_t make_item(logic [ActW-1:0] act, logic [KeyW-1:0] key,
		logic [ImgW-1:0] img, logic signed [CodeW-1:0] code, logic [SeqW-1:0] s);
		req_t r;
		r.action = act;
		r.ext_id = key;
		r.image_id = img;
		r.photcode = code;
		r.seq = s;
		return r;
	endfunction

	function automatic logic [KeyW-1:0] pick_key();
		if ($urandom_range(0, 2) == 0)
			return $urandom();
		return key_pool[$urandom_range(0, 15)];
	endfunction

	// Random item with every field randomized; the action is weighted toward
	// lookups and bumps, and loads are held back so the table stays small and
	// inserts stay cheap until the final fill.
	function automatic req_t random_item();
		req_t r;
		int w;
		int unsigned n;
		n = sb.entries();
		r = make_item(ACT_LOOKUP, pick_key(), $urandom(), CodeW'($urandom()),
			SeqW'($urandom_range(0, 1023)));
		w = $urandom_range(0, 99);
		if (w < 18 && n < 160)
			r.action = ACT_LOAD;
		else if (w < 45)
			r.action = ACT_LOOKUP;
		else if (w < 65)
			r.action = ACT_BUMP_VALID;
		else if (w < 80)
			r.action = ACT_BUMP_INVALID;
		else if (w < 93)
			r.action = ACT_READ;
		else if (w < 94)
			r.action = ACT_CLEAR;
		else if (w < 97)
			r.action = ($urandom_range(0, 1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
		// Most counter items address an entry that exists.
		if (n > 0 && $urandom_range(0, 9) != 0)
			r.seq = SeqW'($urandom_range(0, n - 1));
		return r;
	endfunction

	initial begin
		int unsigned fill;
		req.valid = 1'b0;
		req.data = '0;
		arst_n = 1'b0;
		foreach (key_pool[i])
			key_pool[i] = $urandom();
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: an empty table, extreme field values, equal keys,
		// every action and the unused action codes.
		send_item(make_item(ACT_LOOKUP, 32'h0, '0, '0, '0));
		send_item(make_item(ACT_READ, '0, '0, '0, 10'd0));
		send_item(make_item(ACT_LOAD, 32'h8000_0000, 32'hFFFF_FFFF, 16'sh7FFF, '0));
		send_item(make_item(ACT_LOAD, 32'h0, 32'h0, -16'sh8000, 10'h3FF));
		send_item(make_item(ACT_LOAD, 32'hFFFF_FFFF, 32'hA5A5_5A5A, -16'sd1, '0));
		send_item(make_item(ACT_LOAD, 32'h8000_0000, 32'h1234_5678, 16'sd5, '0));
		send_item(make_item(ACT_LOAD, 32'h8000_0000, 32'h0BAD_F00D, -16'sd7, '0));
		send_item(make_item(ACT_LOOKUP, 32'h8000_0000, '1, '1, '1));
		send_item(make_item(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0));
		send_item(make_item(ACT_LOOKUP, 32'h0, '0, '0, '0));
		send_item(make_item(ACT_LOOKUP, 32'h7FFF_FFFF, '0, '0, '0));
		send_item(make_item(ACT_BUMP_VALID, '0, '0, '0, 10'd0));
		send_item(make_item(ACT_BUMP_VALID, '0, '0, '0, 10'd0));
		send_item(make_item(ACT_BUMP_INVALID, '0, '0, '0, 10'd4));
		send_item(make_item(ACT_BUMP_INVALID, '0, '0, '0, 10'd5));
		send_item(make_item(ACT_READ, '0, '0, '0, 10'd4));
		send_item(make_item(ACT_LOOKUP, 32'h8000_0000, '0, '0, '0));
		send_item(make_item(ACT_READ, '0, '0, '0, 10'h3FF));
		send_item(make_item(ACT_BUMP_VALID, '0, '0, '0, 10'd5));
		send_item(make_item(ACT_SPARE_LO, '1, '1, '1, '1));
		send_item(make_item(ACT_SPARE_HI, '0, '0, '0, '0));
		send_item(make_item(ACT_CLEAR, '0, '0, '0, '0));
		send_item(make_item(ACT_READ, '0, '0, '0, 10'd0));
		send_item(make_item(ACT_LOOKUP, 32'h0, '0, '0, '0));
		idle(1);

		// Random items in bursts. Partway through the receiver holds off for
		// a long stretch while items keep coming, and later the sender waits
		// until every result has come back.
		for (int i = 0; i < 100; i++) begin
			if (i == 30)
				hold_len = 400;
			if (i == 65) begin
				idle(1);
				while (sb.awaited.size() != 0)
					@(posedge clk);
			end
			paced_send(random_item());
		end

		// Fill the table with the largest key. Equal keys append at the end,
		// so nothing has to move, and the table reaches full capacity.
		fill = TableDepthDef - sb.entries();
		for (int unsigned i = 0; i < fill; i++)
			paced_send(make_item(ACT_LOAD, 32'hFFFF_FFFF, $urandom(), CodeW'($urandom()),
				'0));

		// Loads on a full table, then random items on the full table.
		for (int i = 0; i < 3; i++)
			paced_send(make_item(ACT_LOAD, $urandom(), $urandom(), CodeW'($urandom()),
				'0));
		for (int i = 0; i < 60; i++) begin
			req_t r;
			r = random_item();
			if ($urandom_range(0, 3) == 0)
				r.seq = 10'h3FF;
			paced_send(r);
		end
		paced_send(make_item(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0));
		idle(1);

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (!sb.failed && sb.awaited.size() == 0)
			$display("[sorted_key_table_lookup_counters] OK");
		else
			$display("[sorted_key_table_lookup_counters] ERROR");
		$finish;
	end

	// Hard limit for a hung run.
	initial begin
		#60ms;
		$display("[sorted_key_table_lookup_counters] ERROR");
		$finish;
	end

endmodule
